>>> sv/assert_macros.svh
// Assertion macros shared by the checker files.
// Clocked on clock; reset name taken from the including scope.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checked only while reset is low.
`define Y2B_ASSERT(label, prop, msg) \
   label: assert property (@(posedge clock) disable iff (reset) prop) else $error(msg);

// Checked on every edge, reset included.
`define Y2B_ASSERT_ALWAYS(label, prop, msg) \
   label: assert property (@(posedge clock) prop) else $error(msg);

`endif

>>> sv/y2b_pkg.sv
// Types and BT.601 constants for the YUYV to BGR converter.
// No dependencies.
package y2b_pkg;

   // Fixed-point coefficients, scaled by 2^20
   localparam int FRAC_BITS = 20;
   localparam logic signed [31:0] COEF_Y   = 32'sd1220542;
   localparam logic signed [31:0] COEF_U_B = 32'sd2116026;
   localparam logic signed [31:0] COEF_U_G = -32'sd409993;
   localparam logic signed [31:0] COEF_V_G = -32'sd852492;
   localparam logic signed [31:0] COEF_V_R = 32'sd1673527;
   localparam logic signed [31:0] ROUND_HALF = 32'sd1 <<< (FRAC_BITS - 1);
   localparam logic [7:0] LUMA_BASE = 8'd16;
   localparam logic [7:0] CHAN_MAX  = 8'hff;

   // Luma product: 239 * COEF_Y fits in 29 bits
   localparam int LUMA_PROD_W = 29;

   typedef logic signed [31:0] chan_sum_type;
   typedef logic [LUMA_PROD_W-1:0] luma_prod_type;

   typedef struct packed {
      logic [7:0] luma_first;
      logic [7:0] chroma_blue;
      logic [7:0] luma_second;
      logic [7:0] chroma_red;
   } y2b_req_type;

   typedef struct packed {
      logic [7:0] blue_first;
      logic [7:0] green_first;
      logic [7:0] red_first;
      logic [7:0] blue_second;
      logic [7:0] green_second;
      logic [7:0] red_second;
   } y2b_rsp_type;

   typedef struct packed {
      logic [7:0] blue;
      logic [7:0] green;
      logic [7:0] red;
   } pixel_type;

   // Shared chroma offsets (rounding half included)
   typedef struct packed {
      chan_sum_type b_off;
      chan_sum_type g_off;
      chan_sum_type r_off;
   } chroma_off_type;

   // Per-stage load enables from the top-level pipeline control
   typedef struct packed {
      logic s1;
      logic s2;
   } stage_en_type;

   // Saturate a 2^20-scaled channel sum to 0..255
   function automatic logic [7:0] clip_channel(input chan_sum_type sum);
      logic [7:0] res;
      if (sum[31]) begin
         res = 8'd0;
      end else if (|sum[30:28]) begin
         res = CHAN_MAX;
      end else begin
         res = sum[27:20];
      end
      return res;
   endfunction

endpackage

>>> sv/y2b_if.sv
// Valid/ready channel interfaces for request and response beats.
// Depends on y2b_pkg.
interface y2b_req_if import y2b_pkg::*;;
   logic        valid;
   logic        ready;
   y2b_req_type payload;

   modport source(output valid, output payload, input ready);
   modport sink(input valid, input payload, output ready);
endinterface

interface y2b_rsp_if import y2b_pkg::*;;
   logic        valid;
   logic        ready;
   y2b_rsp_type payload;

   modport source(output valid, output payload, input ready);
   modport sink(input valid, input payload, output ready);
endinterface

>>> sv/y2b_chroma.sv
// Shared chroma unit: centers Cb/Cr, multiplies, forms per-channel offsets.
// Depends on y2b_pkg. Two register stages.
module y2b_chroma import y2b_pkg::*; (
   input  logic           clock,
   input  stage_en_type   stage_en,
   input  logic [7:0]     chroma_blue,
   input  logic [7:0]     chroma_red,
   output chroma_off_type offsets
);

   logic signed [7:0] u_c;
   logic signed [7:0] v_c;
   chan_sum_type ub_ff, ug_ff, vg_ff, vr_ff;
   chroma_off_type off_ff, off_in;

   // x - 128 on a byte is a flip of the top bit
   assign u_c = $signed({~chroma_blue[7], chroma_blue[6:0]});
   assign v_c = $signed({~chroma_red[7], chroma_red[6:0]});

   always_ff @(posedge clock) begin
      if (stage_en.s1) begin
         ub_ff <= chan_sum_type'(32'(u_c) * COEF_U_B);
         ug_ff <= chan_sum_type'(32'(u_c) * COEF_U_G);
         vg_ff <= chan_sum_type'(32'(v_c) * COEF_V_G);
         vr_ff <= chan_sum_type'(32'(v_c) * COEF_V_R);
      end
   end

   always_comb begin
      off_in.b_off = ROUND_HALF + ub_ff;
      off_in.g_off = ROUND_HALF + vg_ff + ug_ff;
      off_in.r_off = ROUND_HALF + vr_ff;
   end

   always_ff @(posedge clock) begin
      if (stage_en.s2) begin
         off_ff <= off_in;
      end
   end

   assign offsets = off_ff;

endmodule

>>> sv/y2b_lane.sv
// One pixel lane: luma floor and multiply, then add chroma offsets and saturate.
// Depends on y2b_pkg.
module y2b_lane import y2b_pkg::*; (
   input  logic           clock,
   input  stage_en_type   stage_en,
   input  logic [7:0]     luma,
   input  chroma_off_type offsets,
   output pixel_type      pixel
);

   logic [7:0]    y_floor;
   luma_prod_type prod_s1_ff;
   luma_prod_type prod_s2_ff;
   chan_sum_type  y_term;

   // Luma below the video black level counts as black
   assign y_floor = (luma < LUMA_BASE) ? 8'd0 : luma - LUMA_BASE;

   always_ff @(posedge clock) begin
      if (stage_en.s1) begin
         prod_s1_ff <= LUMA_PROD_W'(32'(y_floor) * COEF_Y);
      end
      if (stage_en.s2) begin
         prod_s2_ff <= prod_s1_ff;
      end
   end

   assign y_term = chan_sum_type'({3'b000, prod_s2_ff});

   always_comb begin
      pixel.blue  = clip_channel(y_term + offsets.b_off);
      pixel.green = clip_channel(y_term + offsets.g_off);
      pixel.red   = clip_channel(y_term + offsets.r_off);
   end

endmodule

>>> sv/yuyv_to_bgr_converter_core.sv
// YUYV macropixel to BGR pixel pair converter, BT.601 video range.
// Requests come in on req_bus (one YUYV macropixel per beat), results leave
// on rsp_bus (two BGR pixels per beat). Depends on y2b_pkg and y2b_if.
//
// Usage:
//   - Each request beat gives exactly one response beat, in order.
//   - The multiply stage loads at the accepting edge, then the chroma offset
//     stage, then the output register where the two lanes add, saturate and
//     merge, and which drives rsp valid.
//   - Throughput is one beat per cycle while the sink takes beats; the rate
//     is set by the three-stage pipeline, each stage loading once per cycle.
//   - When the sink stalls, the output register holds its beat and bubbles
//     ahead of it fill; req ready drops only once all three stages are full.
//   - Synchronous reset clears stage valid bits; data registers are not
//     reset. rsp valid is low the cycle after reset.
//   - The chroma products are shared; two luma lanes run side by side.
//   - No configuration, no state beyond the pipeline.
module yuyv_to_bgr_converter_core import y2b_pkg::*; (
   input  logic             clock,
   input  logic             reset,
   y2b_req_if.sink          req_bus,
   y2b_rsp_if.source        rsp_bus
);

   logic s1_v_ff, s1_v_in;
   logic s2_v_ff, s2_v_in;
   logic out_v_ff, out_v_in;
   logic out_free;
   logic s2_adv;
   logic s1_adv;
   stage_en_type   stage_en;
   chroma_off_type offsets;
   pixel_type      pix_first;
   pixel_type      pix_second;
   y2b_rsp_type    rsp_ff;

   // Stall chain: each stage moves when the one after it has room
   assign out_free = !out_v_ff || rsp_bus.ready;
   assign s2_adv   = !s2_v_ff || out_free;
   assign s1_adv   = !s1_v_ff || s2_adv;

   assign stage_en.s1 = s1_adv;
   assign stage_en.s2 = s2_adv;

   assign req_bus.ready = s1_adv;

   assign s1_v_in  = s1_adv ? req_bus.valid : s1_v_ff;
   assign s2_v_in  = s2_adv ? s1_v_ff : s2_v_ff;
   assign out_v_in = out_free ? s2_v_ff : out_v_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_v_ff  <= 1'b0;
         s2_v_ff  <= 1'b0;
         out_v_ff <= 1'b0;
      end else begin
         s1_v_ff  <= s1_v_in;
         s2_v_ff  <= s2_v_in;
         out_v_ff <= out_v_in;
      end
   end

   // Shared chroma path
   y2b_chroma u_chroma (
      .clock       (clock),
      .stage_en    (stage_en),
      .chroma_blue (req_bus.payload.chroma_blue),
      .chroma_red  (req_bus.payload.chroma_red),
      .offsets     (offsets)
   );

   // Two luma lanes
   y2b_lane u_lane_first (
      .clock    (clock),
      .stage_en (stage_en),
      .luma     (req_bus.payload.luma_first),
      .offsets  (offsets),
      .pixel    (pix_first)
   );

   y2b_lane u_lane_second (
      .clock    (clock),
      .stage_en (stage_en),
      .luma     (req_bus.payload.luma_second),
      .offsets  (offsets),
      .pixel    (pix_second)
   );

   // Merge stage: both lanes land in one output beat
   always_ff @(posedge clock) begin
      if (out_free && s2_v_ff) begin
         rsp_ff.blue_first   <= pix_first.blue;
         rsp_ff.green_first  <= pix_first.green;
         rsp_ff.red_first    <= pix_first.red;
         rsp_ff.blue_second  <= pix_second.blue;
         rsp_ff.green_second <= pix_second.green;
         rsp_ff.red_second   <= pix_second.red;
      end
   end

   assign rsp_bus.valid   = out_v_ff;
   assign rsp_bus.payload = rsp_ff;

endmodule

>>> sv/y2b_checker.sv
// Port-level checks for the converter core, bound to the top level.
// Depends on y2b_pkg and assert_macros.svh.
`include "assert_macros.svh"

module y2b_checker import y2b_pkg::*; (
   input logic        clock,
   input logic        reset,
   input logic        req_ready,
   input logic        rsp_valid,
   input logic        rsp_ready,
   input y2b_rsp_type rsp_payload
);

   logic rsp_stall;

   assign rsp_stall = rsp_valid && !rsp_ready;

   // Stalled response beat holds
   `Y2B_ASSERT(a_rsp_hold, rsp_stall |=> rsp_valid && $stable(rsp_payload), "rsp beat changed")

   // Empty output register means the pipeline has room
   `Y2B_ASSERT(a_ready_when_empty, !rsp_valid |-> req_ready, "req not ready with empty output")

   // A sink that takes beats never throttles the source
   `Y2B_ASSERT(a_ready_follows_sink, rsp_ready |-> req_ready, "req throttled while sink ready")

   // Reset flushes the pipeline
   `Y2B_ASSERT_ALWAYS(a_reset_flush, reset |=> !rsp_valid, "rsp valid right after reset")

endmodule

bind yuyv_to_bgr_converter_core y2b_checker u_y2b_checker (
   .clock       (clock),
   .reset       (reset),
   .req_ready   (req_bus.ready),
   .rsp_valid   (rsp_bus.valid),
   .rsp_ready   (rsp_bus.ready),
   .rsp_payload (rsp_bus.payload)
);

>>> tb/bgr_pair_checker.sv
// Scoreboard for the YUYV to BGR converter: predicts each pixel pair from the
// request beats it sees and compares response beats in order.
// Depends on y2b_pkg (beat types only).
module bgr_pair_checker import y2b_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   input  logic        req_ready,
   input  y2b_req_type req_beat,
   input  logic        rsp_valid,
   input  logic        rsp_ready,
   input  y2b_rsp_type rsp_beat,
   output int          fail_count,
   output int          pending_pairs
);
   timeunit 1ns;
   timeprecision 1ps;

   // BT.601 gains, 2^20 scale
   localparam longint LUMA_GAIN   = 1220542;
   localparam longint CB_TO_BLUE  = 2116026;
   localparam longint CB_TO_GREEN = -409993;
   localparam longint CR_TO_GREEN = -852492;
   localparam longint CR_TO_RED   = 1673527;
   localparam int     SCALE_BITS  = 20;
   localparam longint HALF_LSB    = longint'(1) << (SCALE_BITS - 1);

   localparam string CHANNEL_NAMES [6] = '{"red_second", "green_second", "blue_second",
                                           "red_first", "green_first", "blue_first"};

   y2b_rsp_type pairs_due [$];
   int          mismatches = 0;

   assign fail_count = mismatches;

   function automatic logic [7:0] saturate(input longint sum);
      longint q;
      if (sum < 0) return 8'd0;
      q = sum >>> SCALE_BITS;
      return (q > 255) ? 8'hff : q[7:0];
   endfunction

   // luma floored at 16, no upper clamp
   function automatic longint scaled_luma(input logic [7:0] luma);
      longint y;
      y = luma;
      y = y - 16;
      if (y < 0) y = 0;
      return y * LUMA_GAIN;
   endfunction

   function automatic y2b_rsp_type convert_macropixel(input y2b_req_type px);
      longint cb, cr, b_off, g_off, r_off, y0, y1;
      y2b_rsp_type pair;
      cb = px.chroma_blue;
      cr = px.chroma_red;
      cb = cb - 128;
      cr = cr - 128;
      b_off = HALF_LSB + CB_TO_BLUE * cb;
      g_off = HALF_LSB + CR_TO_GREEN * cr + CB_TO_GREEN * cb;
      r_off = HALF_LSB + CR_TO_RED * cr;
      y0 = scaled_luma(px.luma_first);
      y1 = scaled_luma(px.luma_second);
      pair.blue_first   = saturate(y0 + b_off);
      pair.green_first  = saturate(y0 + g_off);
      pair.red_first    = saturate(y0 + r_off);
      pair.blue_second  = saturate(y1 + b_off);
      pair.green_second = saturate(y1 + g_off);
      pair.red_second   = saturate(y1 + r_off);
      return pair;
   endfunction

   always @(posedge clock) begin : track
      y2b_rsp_type     want;
      logic [5:0][7:0] want_ch;
      logic [5:0][7:0] got_ch;
      if (reset) begin
         pairs_due.delete();
      end else begin
         // response first: a request seen on this edge cannot be answered yet
         if (rsp_valid && rsp_ready) begin
            if (pairs_due.size() == 0) begin
               $display("%0t: unexpected rsp beat %h, no pixel pair outstanding",
                        $time, rsp_beat);
               mismatches++;
            end else begin
               want    = pairs_due.pop_front();
               want_ch = want;
               got_ch  = rsp_beat;
               for (int i = 5; i >= 0; i--) begin
                  if (got_ch[i] !== want_ch[i]) begin
                     $display("%0t: %s mismatch, expected %0d, actual %0d",
                              $time, CHANNEL_NAMES[i], want_ch[i], got_ch[i]);
                     mismatches++;
                  end
               end
            end
         end
         if (req_valid && req_ready) begin
            pairs_due.push_back(convert_macropixel(req_beat));
         end
      end
      pending_pairs <= pairs_due.size();
   end

endmodule

>>> tb/tb_top.sv
// Top of the YUYV to BGR converter testbench: clock, reset, request stimulus,
// response back-pressure, watchdog and verdict. Depends on y2b_pkg, y2b_if,
// yuyv_to_bgr_converter_core and bgr_pair_checker.
module tb_top import y2b_pkg::*;;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int CLK_PERIOD   = 10;
   localparam int RESET_CYCLES = 12;
   localparam int RANDOM_BEATS = 1080;
   localparam int HOLD_CYCLES  = 100;   // long rsp stall to back the pipe up
   localparam int DRAIN_CYCLES = 10;    // margin for the pipeline to drain
   localparam int STALL_LIMIT  = 4000;  // cycles without any beat moving
   localparam int N_CORNERS    = 20;

   // Directed macropixels, packed as {luma_first, Cb, luma_second, Cr}
   localparam y2b_req_type CORNER_BEATS [N_CORNERS] = '{
      32'h00_00_00_00,   // all zero: blue/red sums go negative
      32'hff_ff_ff_ff,   // all ones: blue and red saturate high
      32'h10_80_10_80,   // video black, neutral chroma
      32'heb_80_eb_80,   // video white
      32'hff_80_00_80,   // luma above 235 (no clamp) and luma floored
      32'h0f_80_11_80,   // luma just below and just above the floor
      32'h10_00_10_00,   // minimum chroma on black: negative channel sums
      32'h10_ff_10_ff,   // maximum chroma on black
      32'heb_00_eb_ff,   // white with opposing chroma extremes
      32'heb_ff_eb_00,
      32'h80_00_80_80,   // Cb alone at each extreme
      32'h80_ff_80_80,
      32'h80_80_80_00,   // Cr alone at each extreme
      32'h80_80_80_ff,
      32'haa_55_55_aa,   // alternating bit patterns
      32'h55_aa_aa_55,
      32'h51_5a_51_f0,   // saturated red
      32'h91_36_91_22,   // saturated green
      32'h29_f0_29_6e,   // saturated blue
      32'h01_7f_fe_81    // near-mid chroma, luma at both ends
   };

   // Values near the arithmetic corners, mixed into the random beats
   localparam logic [7:0] EDGE_BYTES [8] = '{8'd0, 8'd15, 8'd16, 8'd17,
                                             8'd128, 8'd235, 8'd236, 8'd255};

   logic clock = 1'b0;
   logic reset = 1'b1;

   // steady: both sides stop idling for a stretch of the random part
   logic steady = 1'b0;
   int   holds_asked = 0;
   int   holds_served = 0;
   int   hold_left = 0;

   int fail_count;
   int pending_pairs;

   y2b_req_if req_bus();
   y2b_rsp_if rsp_bus();

   always #(CLK_PERIOD / 2) clock = ~clock;

   yuyv_to_bgr_converter_core u_top (
      .clock   (clock),
      .reset   (reset),
      .req_bus (req_bus),
      .rsp_bus (rsp_bus)
   );

   bgr_pair_checker u_check (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_bus.valid),
      .req_ready     (req_bus.ready),
      .req_beat      (req_bus.payload),
      .rsp_valid     (rsp_bus.valid),
      .rsp_ready     (rsp_bus.ready),
      .rsp_beat      (rsp_bus.payload),
      .fail_count    (fail_count),
      .pending_pairs (pending_pairs)
   );

   // A quarter of the bytes come from the corner set, the rest uniform
   function automatic logic [7:0] pick_byte();
      if ($urandom_range(3) == 0) return EDGE_BYTES[$urandom_range(7)];
      return 8'($urandom_range(255));
   endfunction

   function automatic y2b_req_type random_macropixel();
      y2b_req_type px;
      px.luma_first  = pick_byte();
      px.chroma_blue = pick_byte();
      px.luma_second = pick_byte();
      px.chroma_red  = pick_byte();
      return px;
   endfunction

   // Offer one beat and return at the edge that accepts it. Gaps go in front,
   // so valid stays high across back-to-back beats with a single NBA per edge.
   task automatic send_macropixel(input y2b_req_type px);
      while (!steady && $urandom_range(99) < 9) begin
         req_bus.valid <= 1'b0;
         @(posedge clock);
      end
      req_bus.valid   <= 1'b1;
      req_bus.payload <= px;
      do @(posedge clock); while (!req_bus.ready);
   endtask

   // Stimulus and verdict
   initial begin
      req_bus.valid   = 1'b0;
      req_bus.payload = '0;
      repeat (RESET_CYCLES) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      foreach (CORNER_BEATS[i]) send_macropixel(CORNER_BEATS[i]);

      for (int n = 0; n < RANDOM_BEATS; n++) begin
         steady = (n >= 300 && n < 500);
         // one long rsp stall while requests keep coming: fills all stages
         if (n == 150) holds_asked++;
         send_macropixel(random_macropixel());
      end
      req_bus.valid <= 1'b0;
      steady = 1'b0;
      // let the checker count the last request beat
      @(posedge clock);

      // drain: outstanding pairs, then a margin for any stray beat
      while (pending_pairs != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);

      if (fail_count == 0) begin
         $display("== PASS ==");
      end else begin
         $display("== FAIL ==");
      end
      $finish;
   end

   // Response side: random stalls, plus the long hold counted here
   initial begin
      rsp_bus.ready = 1'b0;
      forever begin
         @(posedge clock);
         if (reset) begin
            rsp_bus.ready <= 1'b0;
         end else if (hold_left > 0) begin
            hold_left--;
            rsp_bus.ready <= 1'b0;
         end else if (holds_served != holds_asked) begin
            holds_served++;
            hold_left = HOLD_CYCLES - 1;
            rsp_bus.ready <= 1'b0;
         end else begin
            rsp_bus.ready <= steady || ($urandom_range(99) >= 9);
         end
      end
   end

   // Watchdog: ends the run if no beat moves on either channel for too long
   initial begin : watchdog
      int quiet;
      quiet = 0;
      while (quiet < STALL_LIMIT) begin
         @(posedge clock);
         if (reset || (req_bus.valid && req_bus.ready) ||
             (rsp_bus.valid && rsp_bus.ready)) begin
            quiet = 0;
         end else begin
            quiet++;
         end
      end
      $display("%0t: watchdog, no beat accepted in %0d cycles", $time, STALL_LIMIT);
      $display("== FAIL ==");
      $finish;
   end

endmodule
